// ===== src/mlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types, sizes and the sigmoid lookup table of the 4-8-2 perceptron.
// ----------------------------------------------------------------------------
package mlp_pkg;

  localparam int IN_CNT      = 4;
  localparam int HID_CNT     = 8;
  localparam int OUT_CNT     = 2;
  localparam int LANES       = IN_CNT;
  localparam int LANE_W      = $clog2(LANES);
  localparam int HALVES      = HID_CNT / LANES;
  localparam int HB_BASE     = HID_CNT * IN_CNT;
  localparam int OW_BASE     = HB_BASE + HID_CNT;
  localparam int OB_BASE     = OW_BASE + OUT_CNT * HID_CNT;
  localparam int STORE_DEPTH = OB_BASE + OUT_CNT;
  localparam int WROW_CNT    = HID_CNT + OUT_CNT * HALVES;
  localparam int ROW_W       = $clog2(WROW_CNT);
  localparam int BIAS_CNT    = HID_CNT + OUT_CNT;
  localparam int BIAS_W      = $clog2(BIAS_CNT);
  localparam int HID_W       = $clog2(HID_CNT);
  localparam int IDX_W       = 6;
  localparam int FEAT_W      = 9;
  localparam int ACT_W       = 16;
  localparam int WGT_W       = 16;
  localparam int PROD_W      = WGT_W + ACT_W + 1;
  localparam int SUM_W       = 36;
  localparam int HID_FB      = 19;
  localparam int OUT_FB      = 27;
  localparam int HID_SHIFT   = 8;
  localparam int OUT_SHIFT   = 16;

  localparam int SIG_ENTRIES = 256;
  localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);

  // issue schedule: hidden neurons, settle gap, output halves, drain
  localparam int OUT_START   = HID_CNT + 2;
  localparam int OUT_STEPS   = OUT_CNT * HALVES;
  localparam int STEP_W      = $clog2(OUT_STEPS);
  localparam int RUN_LAST    = OUT_START + OUT_STEPS + 1;
  localparam int CNT_W       = $clog2(RUN_LAST + 1);

  typedef logic signed [WGT_W-1:0]  wgt_t;
  typedef logic        [ACT_W-1:0]  act_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [SIG_ENTRIES-1:0][ACT_W-1:0] sig_table_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_WACK
  } mlp_state_e;

  typedef struct packed {
    logic             vld;
    logic             out_phase;
    logic             first;
    logic             last;
    logic [HID_W-1:0] sel;
  } mlp_ctl_t;

  localparam logic [63:0] Q32_ONE    = 64'h1_0000_0000;
  localparam logic [63:0] E_FRAC_Q32 = 64'd3084996963;
  localparam logic [63:0] LOW32      = 64'hFFFF_FFFF;

  function automatic logic [63:0] mul_frac(logic [63:0] v, logic [63:0] f);
    return (v >> 32) * f + (((v & LOW32) * f) >> 32);
  endfunction

  // restoring long division, used only while building the table
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_q32(logic [63:0] n);
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] sum;
    num  = 64'd8 * n;
    q    = num >> SIG_IDX_W;
    r    = (num & 64'(SIG_ENTRIES - 1)) << (32 - SIG_IDX_W);
    term = Q32_ONE;
    sum  = Q32_ONE;
    for (int i = 1; i <= 24; i++) begin
      term = udiv64(mul_frac(term, r), 64'(i));
      sum  = sum + term;
    end
    for (logic [63:0] j = 0; j < q; j++) begin
      sum = 64'd2 * sum + mul_frac(sum, E_FRAC_Q32);
    end
    return sum;
  endfunction

  function automatic logic [ACT_W-1:0] sig_entry(int k);
    logic        m_neg;
    logic [63:0] m_abs;
    logic [63:0] ea;
    logic [63:0] den;
    logic [63:0] numr;
    logic [63:0] v;
    m_neg = (2 * k + 1) < SIG_ENTRIES;
    m_abs = m_neg ? 64'(SIG_ENTRIES - 2 * k - 1) : 64'(2 * k + 1 - SIG_ENTRIES);
    ea    = exp_q32(m_abs);
    den   = Q32_ONE + ea;
    numr  = m_neg ? Q32_ONE : ea;
    v     = udiv64(64'd131070 * numr + den, 64'd2 * den);
    return (v > 64'd65535) ? 16'hFFFF : v[ACT_W-1:0];
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t t;
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      t[k] = sig_entry(k);
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ===== src/mlp_wstore.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_wstore
// Weight and bias store: one bank of weight rows per lane plus a bias file.
// ----------------------------------------------------------------------------
module mlp_wstore (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [mlp_pkg::IDX_W-1:0]  widx_i,
  input  mlp_pkg::wgt_t              wdata_i,
  input  logic [mlp_pkg::ROW_W-1:0]  row_i,
  input  logic [mlp_pkg::BIAS_W-1:0] bidx_i,
  output mlp_pkg::wgt_t              w_o [mlp_pkg::LANES],
  output mlp_pkg::wgt_t              bias_o
);
  import mlp_pkg::*;

  wgt_t              w_q [LANES][WROW_CNT];
  wgt_t              b_q [BIAS_CNT];
  logic              w_we;
  logic              b_we;
  logic [ROW_W-1:0]  w_row;
  logic [LANE_W-1:0] w_bank;
  logic [BIAS_W-1:0] b_idx;
  logic [IDX_W-1:0]  ow_off;

  assign ow_off = IDX_W'(widx_i - IDX_W'(OW_BASE));
  assign w_bank = widx_i[LANE_W-1:0];

  always_comb begin
    w_we  = 1'b0;
    b_we  = 1'b0;
    w_row = '0;
    b_idx = '0;
    if (we_i) begin
      if (widx_i < IDX_W'(HB_BASE)) begin
        w_we  = 1'b1;
        w_row = ROW_W'(widx_i[IDX_W-1:LANE_W]);
      end else if (widx_i < IDX_W'(OW_BASE)) begin
        b_we  = 1'b1;
        b_idx = BIAS_W'(widx_i - IDX_W'(HB_BASE));
      end else if (widx_i < IDX_W'(OB_BASE)) begin
        w_we  = 1'b1;
        w_row = ROW_W'(HID_CNT) + ROW_W'(ow_off[IDX_W-1:LANE_W]);
      end else if (widx_i < IDX_W'(STORE_DEPTH)) begin
        b_we  = 1'b1;
        b_idx = BIAS_W'(HID_CNT) + BIAS_W'(widx_i - IDX_W'(OB_BASE));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        for (int r = 0; r < WROW_CNT; r++) begin
          w_q[i][r] <= '0;
        end
      end
      for (int b = 0; b < BIAS_CNT; b++) begin
        b_q[b] <= '0;
      end
    end else begin
      if (w_we) begin
        w_q[w_bank][w_row] <= wdata_i;
      end
      if (b_we) begin
        b_q[b_idx] <= wdata_i;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      w_o[i] = w_q[i][row_i];
    end
  end

  assign bias_o = b_q[bidx_i];

endmodule

// ===== src/mlp_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_lane
// One multiply lane: signed weight times unsigned activation, registered.
// ----------------------------------------------------------------------------
module mlp_lane (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  mlp_pkg::wgt_t            wgt_i,
  input  mlp_pkg::act_t            act_i,
  output mlp_pkg::prod_t           prod_o
);
  import mlp_pkg::*;

  prod_t prod_q;
  prod_t prod_d;

  assign prod_d = wgt_i * $signed({1'b0, act_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== src/mlp_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_merge
// Merge stage: adds lane products and bias, saturates, looks up sigmoid.
// ----------------------------------------------------------------------------
module mlp_merge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mlp_pkg::mlp_ctl_t ctl_i,
  input  mlp_pkg::wgt_t    bias_i,
  input  mlp_pkg::prod_t   prod_i [mlp_pkg::LANES],
  output mlp_pkg::act_t    hid_o  [mlp_pkg::HID_CNT],
  output mlp_pkg::act_t    act_o  [mlp_pkg::OUT_CNT]
);
  import mlp_pkg::*;

  mlp_ctl_t              ctl_a_q;
  mlp_ctl_t              ctl_b_q;
  wgt_t                  bias_a_q;
  sum_t                  sum_q;
  sum_t                  sum_d;
  sum_t                  psum;
  sum_t                  base;
  act_t                  hid_q [HID_CNT];
  act_t                  act_q [OUT_CNT];
  logic                  hid_rng;
  logic                  out_rng;
  logic [SIG_IDX_W-1:0]  idx_h;
  logic [SIG_IDX_W-1:0]  idx_o;
  logic [SIG_IDX_W-1:0]  idx;
  act_t                  sig_val;

  always_comb begin
    psum = '0;
    for (int i = 0; i < LANES; i++) begin
      psum = psum + SUM_W'(prod_i[i]);
    end
  end

  always_comb begin
    if (ctl_a_q.out_phase) begin
      base = SUM_W'(bias_a_q) <<< OUT_SHIFT;
    end else begin
      base = SUM_W'(bias_a_q) <<< HID_SHIFT;
    end
    if (ctl_a_q.first) begin
      sum_d = base + psum;
    end else begin
      sum_d = sum_q + psum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      bias_a_q <= bias_i;
    end
    if (ctl_a_q.vld) begin
      sum_q <= sum_d;
    end
  end

  // saturate to [-8, 8) and form the table index
  assign hid_rng = (&sum_q[SUM_W-1:HID_FB+3]) | ~(|sum_q[SUM_W-1:HID_FB+3]);
  assign out_rng = (&sum_q[SUM_W-1:OUT_FB+3]) | ~(|sum_q[SUM_W-1:OUT_FB+3]);
  assign idx_h   = {~sum_q[HID_FB+3], sum_q[HID_FB+2:HID_FB+4-SIG_IDX_W]};
  assign idx_o   = {~sum_q[OUT_FB+3], sum_q[OUT_FB+2:OUT_FB+4-SIG_IDX_W]};

  always_comb begin
    if (ctl_b_q.out_phase ? out_rng : hid_rng) begin
      idx = ctl_b_q.out_phase ? idx_o : idx_h;
    end else if (sum_q[SUM_W-1]) begin
      idx = '0;
    end else begin
      idx = '1;
    end
  end

  assign sig_val = SIG_TABLE[idx];

  always_ff @(posedge clk_i) begin
    if (ctl_b_q.vld && ctl_b_q.last) begin
      if (ctl_b_q.out_phase) begin
        act_q[ctl_b_q.sel[$clog2(OUT_CNT)-1:0]] <= sig_val;
      end else begin
        hid_q[ctl_b_q.sel] <= sig_val;
      end
    end
  end

  assign hid_o = hid_q;
  assign act_o = act_q;

endmodule

// ===== src/mlp_sigmoid_inference.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_sigmoid_inference
// 4-8-2 sigmoid perceptron with a loadable weight store.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries one item: req_type_i = 0
// writes weight_value_i at weight_index_i (indices above 57 are dropped but
// still acknowledged); req_type_i = 1 runs inference on in_a_i..in_d_i.
// Output channel (out_valid_o / out_ready_i) returns one item per input item:
// both output activations, the predicted class and a write flag.
// Four multiply lanes evaluate one hidden neuron per cycle, then each output
// neuron in two halves; the merge stage adds the lane products, saturates
// and reads the sigmoid table.
// A write passes through the acknowledge state, an inference through the run
// and finish states. One item is processed at a time: no new item is accepted
// until the current result has been loaded into the output register.
// A finished result waits in the output register; a stalled receiver holds
// the block in its final step, after which it accepts the next item.
// Reset clears all weights and biases to zero and empties the output.
// ----------------------------------------------------------------------------
module mlp_sigmoid_inference (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [mlp_pkg::IDX_W-1:0]   weight_index_i,
  input  logic signed [15:0]          weight_value_i,
  input  logic [mlp_pkg::FEAT_W-1:0]  in_a_i,
  input  logic [mlp_pkg::FEAT_W-1:0]  in_b_i,
  input  logic [mlp_pkg::FEAT_W-1:0]  in_c_i,
  input  logic [mlp_pkg::FEAT_W-1:0]  in_d_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [15:0]                 act_zero_o,
  output logic [15:0]                 act_one_o,
  output logic                        class_out_o,
  output logic                        was_write_o
);
  import mlp_pkg::*;

  mlp_state_e         state_q;
  mlp_state_e         state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   cnt_d;
  logic [FEAT_W-1:0]  x_q [IN_CNT];
  logic               out_valid_q;
  logic               out_valid_d;
  act_t               act_zero_q;
  act_t               act_one_q;
  logic               class_q;
  logic               was_write_q;

  logic               accept;
  logic               store_we;
  logic               load_out;
  logic               hid_issue;
  logic               out_issue;
  logic [STEP_W-1:0]  step;
  logic [ROW_W-1:0]   row;
  logic [BIAS_W-1:0]  bidx;
  mlp_ctl_t           ctl;
  wgt_t               w_rd [LANES];
  wgt_t               bias_rd;
  act_t               lane_act [LANES];
  prod_t              prod [LANES];
  act_t               hid_act [HID_CNT];
  act_t               out_act [OUT_CNT];

  assign accept   = in_valid_i && in_ready_o;
  assign store_we = accept && !req_type_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = req_type_i ? ST_RUN : ST_WACK;
        end
      end
      ST_RUN: begin
        if (cnt_q == CNT_W'(RUN_LAST)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN, ST_WACK: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    hid_issue  = 1'b0;
    out_issue  = 1'b0;
    cnt_d      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_RUN: begin
        cnt_d     = cnt_q + 1'b1;
        hid_issue = cnt_q < CNT_W'(HID_CNT);
        out_issue = (cnt_q >= CNT_W'(OUT_START)) &&
                    (cnt_q < CNT_W'(OUT_START + OUT_STEPS));
      end
      ST_FIN, ST_WACK: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign step = STEP_W'(cnt_q - CNT_W'(OUT_START));

  always_comb begin
    ctl       = '0;
    row       = '0;
    bidx      = '0;
    ctl.vld   = hid_issue || out_issue;
    if (out_issue) begin
      row           = ROW_W'(HID_CNT) + ROW_W'(step);
      bidx          = BIAS_W'(HID_CNT) + BIAS_W'(step >> $clog2(HALVES));
      ctl.out_phase = 1'b1;
      ctl.first     = step[$clog2(HALVES)-1:0] == '0;
      ctl.last      = step[$clog2(HALVES)-1:0] == '1;
      ctl.sel       = HID_W'(step >> $clog2(HALVES));
    end else begin
      row       = ROW_W'(cnt_q);
      bidx      = BIAS_W'(cnt_q);
      ctl.first = 1'b1;
      ctl.last  = 1'b1;
      ctl.sel   = HID_W'(cnt_q);
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (out_issue) begin
        lane_act[i] = hid_act[{step[$clog2(HALVES)-1:0], LANE_W'(i)}];
      end else begin
        lane_act[i] = ACT_W'(x_q[i]);
      end
    end
  end

  mlp_wstore u_wstore (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (store_we),
    .widx_i  (weight_index_i),
    .wdata_i (weight_value_i),
    .row_i   (row),
    .bidx_i  (bidx),
    .w_o     (w_rd),
    .bias_o  (bias_rd)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mlp_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (ctl.vld),
      .wgt_i  (w_rd[g]),
      .act_i  (lane_act[g]),
      .prod_o (prod[g])
    );
  end

  mlp_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .bias_i (bias_rd),
    .prod_i (prod),
    .hid_o  (hid_act),
    .act_o  (out_act)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i) begin
      x_q[0] <= in_a_i;
      x_q[1] <= in_b_i;
      x_q[2] <= in_c_i;
      x_q[3] <= in_d_i;
    end
    if (load_out) begin
      if (state_q == ST_WACK) begin
        act_zero_q  <= '0;
        act_one_q   <= '0;
        class_q     <= 1'b0;
        was_write_q <= 1'b1;
      end else begin
        act_zero_q  <= out_act[0];
        act_one_q   <= out_act[1];
        class_q     <= !(out_act[0] > out_act[1]);
        was_write_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign act_zero_o  = act_zero_q;
  assign act_one_o   = act_one_q;
  assign class_out_o = class_q;
  assign was_write_o = was_write_q;

endmodule

// ===== src/mlp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_checker
// Port-level checks of the perceptron, bound to the top level.
// ----------------------------------------------------------------------------
module mlp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        req_type_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] act_zero_o,
  input logic [15:0] act_one_o,
  input logic        class_out_o,
  input logic        was_write_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(act_zero_o) &&
    $stable(act_one_o) && $stable(class_out_o) && $stable(was_write_o))
    else $error("output item changed while stalled");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_write_o |->
    act_zero_o == 16'd0 && act_one_o == 16'd0 && !class_out_o)
    else $error("write acknowledge carries non-zero fields");

  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_write_o |-> class_out_o == (act_zero_o <= act_one_o))
    else $error("class does not match activations");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i |=> !in_ready_o)
    else $error("item accepted during inference");

endmodule

bind mlp_sigmoid_inference mlp_checker u_mlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .act_zero_o  (act_zero_o),
  .act_one_o   (act_one_o),
  .class_out_o (class_out_o),
  .was_write_o (was_write_o)
);
